/* src/srdiv_pkg.sv */
// shared constants and stage payload type for the signed restoring divider
package srdiv_pkg;

    localparam int DATA_W  = 32;
    localparam int STEPS   = DATA_W;
    localparam int LATENCY = STEPS + 2;

    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ONE      = {{(DATA_W-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [DATA_W-1:0] rem;       // partial remainder
        logic [DATA_W-1:0] num;       // dividend magnitude bits still to shift in
        logic [DATA_W-1:0] den;       // divisor magnitude
        logic [DATA_W-1:0] quo;       // quotient bits found so far
        logic              neg;       // result sign
        logic              special;   // fixed result, skip the division
        logic [DATA_W-1:0] spec_val;
    } stage_t;

endpackage

/* src/srdiv_prep.sv */
// input stage: operand magnitudes, result sign and special-case decode
module srdiv_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [srdiv_pkg::DATA_W-1:0]    dividend,
    input  logic signed [srdiv_pkg::DATA_W-1:0]    divisor,
    output logic                                   valid,
    output srdiv_pkg::stage_t                      stage
);

    logic              valid_reg;
    logic              valid_next;
    srdiv_pkg::stage_t stage_reg;
    srdiv_pkg::stage_t stage_next;

    logic [srdiv_pkg::DATA_W-1:0] x;
    logic [srdiv_pkg::DATA_W-1:0] y;
    logic                         x_min;
    logic                         y_min;

    always_comb
    begin
        x     = dividend;
        y     = divisor;
        x_min = (x == srdiv_pkg::MOST_NEG);
        y_min = (y == srdiv_pkg::MOST_NEG);

        valid_next          = start;
        stage_next.rem      = '0;
        stage_next.num      = x[srdiv_pkg::DATA_W-1] ? (~x + srdiv_pkg::ONE) : x;
        stage_next.den      = y[srdiv_pkg::DATA_W-1] ? (~y + srdiv_pkg::ONE) : y;
        stage_next.quo      = '0;
        stage_next.neg      = x[srdiv_pkg::DATA_W-1] ^ y[srdiv_pkg::DATA_W-1];
        stage_next.special  = 1'b1;
        stage_next.spec_val = '0;

        if (x_min && y_min)
        begin
            stage_next.spec_val = srdiv_pkg::ONE;
        end
        else if (y_min)
        begin
            stage_next.spec_val = '0;
        end
        else if (y == '0)
        begin
            // divide by zero: +max or -max by dividend sign
            stage_next.spec_val = x[srdiv_pkg::DATA_W-1] ?
                                  (~srdiv_pkg::MOST_POS + srdiv_pkg::ONE) :
                                  srdiv_pkg::MOST_POS;
        end
        else if (x_min && (y == srdiv_pkg::ALL_ONES))
        begin
            stage_next.spec_val = srdiv_pkg::MOST_POS;
        end
        else
        begin
            stage_next.special = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

/* src/srdiv_step.sv */
// one restoring shift-subtract step, one quotient bit per stage
module srdiv_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  srdiv_pkg::stage_t in_stage,
    output logic              out_valid,
    output srdiv_pkg::stage_t out_stage
);

    logic              valid_reg;
    srdiv_pkg::stage_t stage_reg;
    srdiv_pkg::stage_t stage_next;

    logic [srdiv_pkg::DATA_W:0]   trial;
    logic [srdiv_pkg::DATA_W+1:0] diff;
    logic                         fits;

    always_comb
    begin
        trial = {in_stage.rem, in_stage.num[srdiv_pkg::DATA_W-1]};
        diff  = {1'b0, trial} - {2'b00, in_stage.den};
        fits  = ~diff[srdiv_pkg::DATA_W+1];

        stage_next     = in_stage;
        // remainder stays below the divisor, so the low bits hold it
        stage_next.rem = fits ? diff[srdiv_pkg::DATA_W-1:0] : trial[srdiv_pkg::DATA_W-1:0];
        stage_next.num = {in_stage.num[srdiv_pkg::DATA_W-2:0], 1'b0};
        stage_next.quo = {in_stage.quo[srdiv_pkg::DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

/* src/srdiv_fix.sv */
// output stage: sign fix, special-case select and result register
module srdiv_fix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  srdiv_pkg::stage_t                   in_stage,
    output logic                                done,
    output logic signed [srdiv_pkg::DATA_W-1:0] quotient
);

    logic                         done_reg;
    logic [srdiv_pkg::DATA_W-1:0] quot_reg;
    logic [srdiv_pkg::DATA_W-1:0] quot_next;

    always_comb
    begin
        if (in_stage.special)
        begin
            quot_next = in_stage.spec_val;
        end
        else if (in_stage.neg)
        begin
            quot_next = ~in_stage.quo + srdiv_pkg::ONE;
        end
        else
        begin
            quot_next = in_stage.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* src/signed_restoring_divider_unit.sv */
// top level of the pipelined 32-bit signed restoring divider
//
// usage
// - command channel: drive dividend and divisor and raise start; the item is
//   taken at any rising edge where start is high and busy is low. busy is
//   always low, so a new item can be issued on every cycle
// - result channel: done is high for exactly one cycle with quotient valid in
//   that same cycle; results leave in issue order and cannot be held off
// - pipeline: one input register, 32 shift-subtract stages (one quotient bit
//   each, one 34-bit subtract and compare per stage) and one output
//   register; done rises once the item has passed through all of them
// - throughput: one item per cycle, set by the fully unrolled step chain
// - quotient truncates toward zero; divide by zero gives +max for a
//   non-negative dividend and -max for a negative one; most-negative over
//   minus one saturates to +max; a most-negative divisor gives 0, or 1 when
//   the dividend is also most negative
// - reset: asynchronous, clears every valid bit in the chain, so no result
//   comes out for an item that was in flight when reset hit
module signed_restoring_divider_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [srdiv_pkg::DATA_W-1:0] dividend,
    input  logic signed [srdiv_pkg::DATA_W-1:0] divisor,
    output logic                                done,
    output logic signed [srdiv_pkg::DATA_W-1:0] quotient
);

    // valid bit and payload at the output of each stage; index 0 is the
    // input register, index STEPS the last division step
    logic              valid_pipe [0:srdiv_pkg::STEPS];
    srdiv_pkg::stage_t stage_pipe [0:srdiv_pkg::STEPS];

    // the pipeline never stalls
    assign busy = 1'b0;

    // magnitudes, sign and special-case decode
    srdiv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (dividend),
        .divisor  (divisor),
        .valid    (valid_pipe[0]),
        .stage    (stage_pipe[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < srdiv_pkg::STEPS; i++)
    begin : g_step
        srdiv_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_pipe[i]),
            .in_stage  (stage_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_stage (stage_pipe[i+1])
        );
    end

    // apply the sign or substitute the fixed result
    srdiv_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_pipe[srdiv_pkg::STEPS]),
        .in_stage (stage_pipe[srdiv_pkg::STEPS]),
        .done     (done),
        .quotient (quotient)
    );

    // every accepted item comes out as a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(srdiv_pkg::LATENCY) done)
        else $error("item lost in the divider pipeline");

    // no result without a matching accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, srdiv_pkg::LATENCY))
        else $error("result without an accepted item");

    // division by one returns the dividend
    a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (divisor == srdiv_pkg::ONE)) |-> ##(srdiv_pkg::LATENCY)
        (quotient == $past(dividend, srdiv_pkg::LATENCY)))
        else $error("division by one does not return the dividend");

    // non-negative dividend over zero saturates to the largest positive value
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (divisor == '0) && !dividend[srdiv_pkg::DATA_W-1])
        |-> ##(srdiv_pkg::LATENCY) (quotient == srdiv_pkg::MOST_POS))
        else $error("divide by zero result wrong");

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the pipelined signed restoring divider
`timescale 1ns / 1ps

// operands and predicted quotient of one accepted item
typedef struct {
    logic [srdiv_pkg::DATA_W-1:0] dividend;
    logic [srdiv_pkg::DATA_W-1:0] divisor;
    logic [srdiv_pkg::DATA_W-1:0] quotient;
} div_item_t;

// in-order scoreboard: an accepted item pushes its quotient, each done pops one
class quotient_scoreboard;
    div_item_t pending_q[$];
    int        issued;
    int        checked;
    int        mismatches;
    int        zero_divisors;
    int        most_neg_operands;

    // truncating signed division with the fixed special-case values
    function automatic logic [srdiv_pkg::DATA_W-1:0] truncated_quotient(
        logic [srdiv_pkg::DATA_W-1:0] num,
        logic [srdiv_pkg::DATA_W-1:0] den);
        logic [63:0]                  rest;
        logic [63:0]                  den_mag;
        logic [srdiv_pkg::DATA_W-1:0] mag_q;
        logic [srdiv_pkg::DATA_W-1:0] num_abs;
        logic [srdiv_pkg::DATA_W-1:0] den_abs;
        if (num == srdiv_pkg::MOST_NEG && den == srdiv_pkg::MOST_NEG)
            return srdiv_pkg::ONE;
        if (den == srdiv_pkg::MOST_NEG)
            return '0;
        if (den == '0)
            return num[srdiv_pkg::DATA_W-1] ? (~srdiv_pkg::MOST_POS + srdiv_pkg::ONE) :
                                              srdiv_pkg::MOST_POS;
        if (num == srdiv_pkg::MOST_NEG && den == srdiv_pkg::ALL_ONES)
            return srdiv_pkg::MOST_POS;
        // magnitudes; most negative comes out as 2^31 read unsigned
        num_abs = num[srdiv_pkg::DATA_W-1] ? (~num + srdiv_pkg::ONE) : num;
        den_abs = den[srdiv_pkg::DATA_W-1] ? (~den + srdiv_pkg::ONE) : den;
        rest    = 64'(num_abs);
        den_mag = 64'(den_abs);
        mag_q   = '0;
        for (int i = srdiv_pkg::DATA_W - 1; i >= 0; i--)
        begin
            if ((rest >> i) >= den_mag)
            begin
                mag_q[i] = 1'b1;
                rest     = rest - (den_mag << i);
            end
        end
        return (num[srdiv_pkg::DATA_W-1] ^ den[srdiv_pkg::DATA_W-1]) ?
               (~mag_q + srdiv_pkg::ONE) : mag_q;
    endfunction

    function void note_operands(logic [srdiv_pkg::DATA_W-1:0] num,
                                logic [srdiv_pkg::DATA_W-1:0] den);
        div_item_t it;
        it.dividend = num;
        it.divisor  = den;
        it.quotient = truncated_quotient(num, den);
        pending_q   = {pending_q, it};
        issued++;
        if (den == '0)
            zero_divisors++;
        if (num == srdiv_pkg::MOST_NEG || den == srdiv_pkg::MOST_NEG)
            most_neg_operands++;
    endfunction

    function void check_quotient(logic [srdiv_pkg::DATA_W-1:0] got);
        div_item_t it;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: quotient %h with no item outstanding", $realtime, got);
            return;
        end
        it = pending_q.pop_front();
        checked++;
        if (got !== it.quotient)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %h / %h expected quotient %h, got %h", $realtime,
                         it.dividend, it.divisor, it.quotient, got);
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module tb_top;

    localparam int RANDOM_ITEMS = 1650;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic signed [srdiv_pkg::DATA_W-1:0] dividend = '0;
    logic signed [srdiv_pkg::DATA_W-1:0] divisor = '0;
    logic                                busy;
    logic                                done;
    logic signed [srdiv_pkg::DATA_W-1:0] quotient;

    quotient_scoreboard quot_sb;

    signed_restoring_divider_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #300000;
        $display("signed_restoring_divider_unit verification failed");
        $finish;
    end

    // monitor: both handshakes are sampled at the edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a quotient is valid only in its done cycle, so take it here
            if (done)
                quot_sb.check_quotient(quotient);
            // item taken when start is high and busy low at this edge
            if (start && !busy)
                quot_sb.note_operands(dividend, divisor);
        end
    end

    // present one item and hold it until the edge that takes it
    task automatic issue(input logic [srdiv_pkg::DATA_W-1:0] a,
                         input logic [srdiv_pkg::DATA_W-1:0] b);
        start    <= 1'b1;
        dividend <= a;
        divisor  <= b;
        // busy only moves on a rising edge, so its value at the falling edge
        // is the one the next rising edge sees
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // sender gap; operand buses carry noise while start is low
    task automatic pause(input int cycles);
        start    <= 1'b0;
        dividend <= $urandom;
        divisor  <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // values at the edges of the signed range and around zero
    function automatic logic [srdiv_pkg::DATA_W-1:0] corner_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return srdiv_pkg::ONE;
            2:       return srdiv_pkg::ALL_ONES;
            3:       return srdiv_pkg::MOST_NEG;
            4:       return srdiv_pkg::MOST_POS;
            5:       return srdiv_pkg::MOST_NEG + srdiv_pkg::ONE;
            6:       return 32'd2;
            default: return srdiv_pkg::ALL_ONES - srdiv_pkg::ONE;
        endcase
    endfunction

    // small signed value in [-lim, lim]
    function automatic logic [srdiv_pkg::DATA_W-1:0] small_value(input int lim);
        int v;
        v = int'($urandom_range(0, 2 * lim)) - lim;
        return v[srdiv_pkg::DATA_W-1:0];
    endfunction

    // random operand pair, mixing full-range noise with shapes that hit
    // short quotients, exact multiples, zero divisors and most-negative values
    task automatic random_pair(output logic [srdiv_pkg::DATA_W-1:0] a,
                               output logic [srdiv_pkg::DATA_W-1:0] b);
        int mult;
        int fac;
        int prod;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                a = $urandom;
                b = $urandom;
            end
            3:
            begin
                a = small_value(300);
                b = small_value(300);
            end
            4:
            begin
                a = $urandom;
                b = small_value(20);
            end
            5:
            begin
                // exact multiple, no remainder; product stays inside 31 bits
                mult = int'($urandom_range(1, 65535));
                fac  = int'($urandom_range(0, 32767));
                if ($urandom_range(0, 1))
                    mult = -mult;
                if ($urandom_range(0, 1))
                    fac = -fac;
                prod = mult * fac;
                a    = prod[srdiv_pkg::DATA_W-1:0];
                b    = mult[srdiv_pkg::DATA_W-1:0];
            end
            6:
            begin
                a = corner_value();
                b = corner_value();
            end
            7:
            begin
                a = $urandom;
                b = '0;
            end
            8:
            begin
                a = corner_value();
                b = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    b = ~b + srdiv_pkg::ONE;
            end
            default:
            begin
                // operands of random bit length, so every quotient width shows up
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    a = ~a + srdiv_pkg::ONE;
                if ($urandom_range(0, 1))
                    b = ~b + srdiv_pkg::ONE;
            end
        endcase
    endtask

    initial
    begin
        logic [srdiv_pkg::DATA_W-1:0] a;
        logic [srdiv_pkg::DATA_W-1:0] b;
        int                           sent;
        int                           burst;
        int                           gap;
        int                           drain;

        quot_sb = new();

        // reset held low from time zero, then released on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range extremes, signs, and every special case
        issue(32'd0,                   32'd1);
        issue(32'd1,                   32'd1);
        issue(srdiv_pkg::ALL_ONES,     32'd1);
        issue(srdiv_pkg::MOST_NEG,     srdiv_pkg::MOST_NEG);     // both most negative
        issue(32'd5,                   srdiv_pkg::MOST_NEG);     // most-negative divisor
        issue(srdiv_pkg::ALL_ONES,     srdiv_pkg::MOST_NEG);
        issue(srdiv_pkg::MOST_POS,     srdiv_pkg::MOST_NEG);
        issue(srdiv_pkg::MOST_NEG,     srdiv_pkg::ALL_ONES);     // saturating case
        issue(srdiv_pkg::MOST_NEG,     32'd1);                   // 2^31 magnitude
        issue(srdiv_pkg::MOST_NEG,     32'd2);
        issue(srdiv_pkg::MOST_NEG,     srdiv_pkg::ALL_ONES - srdiv_pkg::ONE);
        issue(srdiv_pkg::MOST_NEG,     32'd3);
        issue(srdiv_pkg::MOST_NEG,     srdiv_pkg::MOST_POS);
        issue(srdiv_pkg::MOST_POS,     32'd1);
        issue(srdiv_pkg::MOST_POS,     srdiv_pkg::ALL_ONES);
        issue(srdiv_pkg::MOST_POS,     srdiv_pkg::MOST_POS);
        issue(32'd7,                   32'd0);                   // divide by zero
        issue(-32'sd7,                 32'd0);
        issue(32'd0,                   32'd0);
        issue(srdiv_pkg::MOST_NEG,     32'd0);
        issue(srdiv_pkg::MOST_POS,     32'd0);
        issue(-32'sd7,                 32'd2);
        issue(32'd7,                   -32'sd2);
        issue(-32'sd7,                 -32'sd2);
        issue(32'd1,                   srdiv_pkg::MOST_POS);
        pause(3);

        // random bursts with random gaps; about a quarter of gaps are zero,
        // so long back-to-back stretches run through the full pipeline
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++)
            begin
                random_pair(a, b);
                issue(a, b);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                pause(gap);
        end
        start <= 1'b0;

        // drain the pipeline, then keep idling past the pipeline latency to catch extras
        drain = 0;
        while (quot_sb.outstanding() != 0 && drain < 10 * srdiv_pkg::LATENCY)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (srdiv_pkg::LATENCY + 4) @(posedge clk);

        $display("items issued: %0d, quotients checked: %0d, mismatches: %0d",
                 quot_sb.issued, quot_sb.checked, quot_sb.mismatches);
        $display("zero divisors: %0d, items with a most-negative operand: %0d",
                 quot_sb.zero_divisors, quot_sb.most_neg_operands);
        if (quot_sb.mismatches == 0 && quot_sb.outstanding() == 0)
            $display("signed_restoring_divider_unit verification clean");
        else
            $display("signed_restoring_divider_unit verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/srdiv_pkg.sv
src/srdiv_prep.sv
src/srdiv_step.sv
src/srdiv_fix.sv
src/signed_restoring_divider_unit.sv
dv/tb_top.sv
